FILE: hdl/bdclp_pkg.sv
package bdclp_pkg;

    localparam int MAX_BUTTONS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TIME   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TIME = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTONS_IN_USE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LOW_MASK = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_CODE_TABLE  = 3'd4;

    localparam logic [15:0] DEBOUNCE_TIME_RST   = 16'd30;
    localparam logic [15:0] LONG_PRESS_TIME_RST = 16'd1000;
    localparam logic [3:0]  BUTTONS_IN_USE_RST  = 4'd8;
    localparam logic [7:0]  ACTIVE_LOW_MASK_RST = 8'hFF;
    localparam logic [63:0] KEY_CODE_TABLE_RST  = 64'd0;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic [7:0]  pin_levels;
    } in_item_t;

    typedef struct packed {
        logic       event_valid;
        logic [7:0] event_key;
        logic       event_long;
        logic [3:0] events_pending;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SERVICE,
        ST_READ,
        ST_POP
    } state_t;

    typedef struct packed {
        logic capture;
        logic service;
        logic read;
        logic pop;
    } cmd_t;

    typedef struct packed {
        logic last_button;
        logic no_buttons;
    } status_t;

endpackage

FILE: hdl/bdclp_ctrl.sv
module bdclp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bdclp_pkg::status_t status,
    output bdclp_pkg::cmd_t    cmd
);

    bdclp_pkg::state_t state_reg;
    bdclp_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdclp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.no_buttons ? bdclp_pkg::ST_READ
                                                   : bdclp_pkg::ST_SERVICE;
                end
            end
            bdclp_pkg::ST_SERVICE:
            begin
                if (status.last_button)
                begin
                    state_next = bdclp_pkg::ST_READ;
                end
            end
            bdclp_pkg::ST_READ:
            begin
                state_next = bdclp_pkg::ST_POP;
            end
            bdclp_pkg::ST_POP:
            begin
                if (out_free)
                begin
                    state_next = bdclp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdclp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            bdclp_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            bdclp_pkg::ST_SERVICE:
            begin
                cmd.service = 1'b1;
            end
            bdclp_pkg::ST_READ:
            begin
                cmd.read = 1'b1;
            end
            bdclp_pkg::ST_POP:
            begin
                cmd.pop = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdclp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/bdclp_dp.sv
module bdclp_dp #(
    parameter int MAX_BUTTONS = bdclp_pkg::MAX_BUTTONS_DEF,
    parameter int QUEUE_DEPTH = bdclp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bdclp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bdclp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  bdclp_pkg::in_item_t                 in_data,
    output bdclp_pkg::out_item_t                out_data,
    input  bdclp_pkg::cmd_t                     cmd,
    output bdclp_pkg::status_t                  status
);

    localparam int BW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    logic [15:0] debounce_reg;
    logic [15:0] long_time_reg;
    logic [3:0]  buttons_reg;
    logic [7:0]  mask_reg;
    logic [63:0] key_table_reg;

    logic        op_reg;
    logic [31:0] now_reg;
    logic [7:0]  levels_reg;
    logic [BW-1:0] idx_reg;

    logic [MAX_BUTTONS-1:0] raw_reg;
    logic [MAX_BUTTONS-1:0] stable_reg;
    logic [MAX_BUTTONS-1:0] long_done_reg;
    logic [31:0]            edge_stamp_reg  [MAX_BUTTONS];
    logic [31:0]            press_stamp_reg [MAX_BUTTONS];

    logic [8:0]    fifo_mem [QUEUE_DEPTH];
    logic [8:0]    rd_data_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail;

    bdclp_pkg::out_item_t out_data_reg;
    bdclp_pkg::out_item_t out_data_next;

    logic [3:0]  n_sat;
    logic        pressed;
    logic        changed;
    logic        db_ok;
    logic        settle;
    logic        short_ev;
    logic        long_ev;
    logic        push;
    logic        do_pop;
    logic [7:0]  key_sel;
    logic [31:0] edge_diff;
    logic [31:0] press_diff;

    assign n_sat = (buttons_reg > 4'(MAX_BUTTONS)) ? 4'(MAX_BUTTONS) : buttons_reg;
    assign status.no_buttons  = (n_sat == 4'd0);
    assign status.last_button = (4'(idx_reg) == (n_sat - 4'd1));

    // per-button debounce and press timing
    assign pressed    = levels_reg[3'(idx_reg)] ^ mask_reg[3'(idx_reg)];
    assign key_sel    = key_table_reg[{3'(idx_reg), 3'b000} +: 8];
    assign changed    = (pressed != raw_reg[idx_reg]);
    assign edge_diff  = now_reg - edge_stamp_reg[idx_reg];
    assign press_diff = now_reg - press_stamp_reg[idx_reg];
    assign db_ok      = changed ? (debounce_reg == 16'd0)
                                : (edge_diff >= 32'(debounce_reg));
    assign settle     = (pressed != stable_reg[idx_reg]) && db_ok;
    assign short_ev   = settle && !pressed && !long_done_reg[idx_reg];
    assign long_ev    = settle ? (pressed && (long_time_reg == 16'd0))
                               : (stable_reg[idx_reg] && !long_done_reg[idx_reg] &&
                                  (press_diff >= 32'(long_time_reg)));
    assign push       = cmd.service && (short_ev || long_ev) &&
                        (count_reg < CW'(QUEUE_DEPTH));

    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : AW'(tail_sum);

    assign do_pop = cmd.pop && op_reg && (count_reg != '0);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (push)
        begin
            count_next = count_reg + CW'(1);
        end
        if (do_pop)
        begin
            head_next  = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        out_data_next                = out_data_reg;
        if (cmd.pop)
        begin
            out_data_next.event_valid    = do_pop;
            out_data_next.event_key      = do_pop ? rd_data_reg[7:0] : 8'd0;
            out_data_next.event_long     = do_pop && rd_data_reg[8];
            out_data_next.events_pending = 4'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= bdclp_pkg::DEBOUNCE_TIME_RST;
            long_time_reg <= bdclp_pkg::LONG_PRESS_TIME_RST;
            buttons_reg   <= bdclp_pkg::BUTTONS_IN_USE_RST;
            mask_reg      <= bdclp_pkg::ACTIVE_LOW_MASK_RST;
            key_table_reg <= bdclp_pkg::KEY_CODE_TABLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bdclp_pkg::REG_DEBOUNCE_TIME:   debounce_reg  <= cfg_data[15:0];
                bdclp_pkg::REG_LONG_PRESS_TIME: long_time_reg <= cfg_data[15:0];
                bdclp_pkg::REG_BUTTONS_IN_USE:  buttons_reg   <= cfg_data[3:0];
                bdclp_pkg::REG_ACTIVE_LOW_MASK: mask_reg      <= cfg_data[7:0];
                bdclp_pkg::REG_KEY_CODE_TABLE:  key_table_reg <= cfg_data;
                default:                        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= in_data.op;
            now_reg    <= in_data.now_ms;
            levels_reg <= in_data.pin_levels;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.capture)
        begin
            idx_reg <= '0;
        end
        else if (cmd.service)
        begin
            idx_reg <= idx_reg + BW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg       <= '0;
            stable_reg    <= '0;
            long_done_reg <= '0;
            for (int i = 0; i < MAX_BUTTONS; i++)
            begin
                edge_stamp_reg[i]  <= '0;
                press_stamp_reg[i] <= '0;
            end
        end
        else if (cmd.service)
        begin
            raw_reg[idx_reg] <= pressed;
            if (changed)
            begin
                edge_stamp_reg[idx_reg] <= now_reg;
            end
            if (settle)
            begin
                stable_reg[idx_reg] <= pressed;
                if (pressed)
                begin
                    press_stamp_reg[idx_reg] <= now_reg;
                end
            end
            if (long_ev)
            begin
                long_done_reg[idx_reg] <= 1'b1;
            end
            else if (settle && pressed)
            begin
                long_done_reg[idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[tail] <= {long_ev, key_sel};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_data_reg <= fifo_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_data = out_data_reg;

endmodule

FILE: hdl/button_debounce_click_long_press.sv
// Button debouncer with short-click and long-press event queue.
//
// Input channel (in_valid/in_ready/in_data): one transfer per sample, carrying
// the millisecond timestamp, the raw pin levels and an op bit (1 = poll).
// Output channel (out_valid/out_ready/out_data): exactly one result per input
// transfer, holding the popped event (if any) and the queue fill after it.
// Configuration (cfg_we/cfg_index/cfg_data): single-cycle register writes.
// It is up to the user to issue them only while the block is idle.
//
// Timing: the serviced buttons are walked one per cycle through a single
// debounce/timer datapath, then the event queue memory is read and popped.
// The serviced button count is the buttons-in-use setting capped at
// MAX_BUTTONS (0..MAX_BUTTONS); a new sample is taken only once the
// previous one's result has entered the output register.
// A result sits in the output register until taken; the next input transfer
// is taken meanwhile, and its pop waits for the output register to free up.
// Reset clears all button state, the queue pointers and the registers to
// their defaults; queue entries themselves are not cleared.
module button_debounce_click_long_press #(
    parameter int MAX_BUTTONS = bdclp_pkg::MAX_BUTTONS_DEF,
    parameter int QUEUE_DEPTH = bdclp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bdclp_pkg::in_item_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bdclp_pkg::out_item_t                out_data,
    input  logic                                cfg_we,
    input  logic [bdclp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bdclp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bdclp_pkg::cmd_t    cmd;
    bdclp_pkg::status_t status;

    bdclp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bdclp_dp #(
        .MAX_BUTTONS (MAX_BUTTONS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: hdl/bdclp_checker.sv
module bdclp_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input bdclp_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_empty_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.event_valid |->
            out_data.event_key == 8'd0 && !out_data.event_long)
        else $error("event fields set without a popped event");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without an item in progress");

endmodule

bind button_debounce_click_long_press bdclp_checker u_chk (.*);

FILE: bench/button_event_checker.sv
`timescale 1ns / 100ps

module button_event_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  bdclp_pkg::in_item_t               in_data,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  bdclp_pkg::out_item_t              out_data,
    input  logic                              cfg_we,
    input  logic [bdclp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bdclp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                fail_count,
    output int                                events_outstanding,
    output int                                results_checked,
    output int                                events_popped
);

    logic [15:0] debounce_ms;
    logic [15:0] long_ms;
    logic [3:0]  buttons_in_use;
    logic [7:0]  active_low_mask;
    logic [63:0] key_codes;

    logic        raw_down    [bdclp_pkg::MAX_BUTTONS_DEF];
    logic        stable_down [bdclp_pkg::MAX_BUTTONS_DEF];
    logic        long_fired  [bdclp_pkg::MAX_BUTTONS_DEF];
    logic [31:0] edge_stamp  [bdclp_pkg::MAX_BUTTONS_DEF];
    logic [31:0] press_stamp [bdclp_pkg::MAX_BUTTONS_DEF];
    logic [8:0]  queued_events[$];

    bdclp_pkg::out_item_t expected_events[$];
    bdclp_pkg::out_item_t want;
    int          mismatches;
    int          checked;
    int          popped;

    function automatic void queue_event(input logic [7:0] key, input logic is_long);
        if (queued_events.size() < bdclp_pkg::QUEUE_DEPTH_DEF)
            queued_events.push_back({is_long, key});
    endfunction

    function automatic bdclp_pkg::out_item_t step_buttons(input bdclp_pkg::in_item_t item);
        bdclp_pkg::out_item_t res;
        int          count;
        int          i;
        logic        pressed;
        logic [7:0]  key;
        logic [31:0] age;
        logic [8:0]  head;
        res = '0;
        count = (buttons_in_use > 4'd8) ? bdclp_pkg::MAX_BUTTONS_DEF : int'(buttons_in_use);
        for (i = 0; i < count; i++)
        begin
            pressed = active_low_mask[i] ? ~item.pin_levels[i] : item.pin_levels[i];
            key = key_codes[8*i +: 8];
            if (pressed != raw_down[i])
            begin
                raw_down[i] = pressed;
                edge_stamp[i] = item.now_ms;
            end
            age = item.now_ms - edge_stamp[i];
            if (raw_down[i] != stable_down[i] && age >= {16'd0, debounce_ms})
            begin
                stable_down[i] = raw_down[i];
                if (stable_down[i])
                begin
                    press_stamp[i] = item.now_ms;
                    long_fired[i] = 1'b0;
                end
                else if (!long_fired[i])
                begin
                    queue_event(key, 1'b0);
                end
            end
            age = item.now_ms - press_stamp[i];
            if (stable_down[i] && !long_fired[i] && age >= {16'd0, long_ms})
            begin
                long_fired[i] = 1'b1;
                queue_event(key, 1'b1);
            end
        end
        if (item.op && queued_events.size() > 0)
        begin
            head = queued_events.pop_front();
            res.event_valid = 1'b1;
            res.event_key = head[7:0];
            res.event_long = head[8];
        end
        res.events_pending = 4'(queued_events.size());
        return res;
    endfunction

    task automatic check_field(input string field, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms = bdclp_pkg::DEBOUNCE_TIME_RST;
            long_ms = bdclp_pkg::LONG_PRESS_TIME_RST;
            buttons_in_use = bdclp_pkg::BUTTONS_IN_USE_RST;
            active_low_mask = bdclp_pkg::ACTIVE_LOW_MASK_RST;
            key_codes = bdclp_pkg::KEY_CODE_TABLE_RST;
            for (int b = 0; b < bdclp_pkg::MAX_BUTTONS_DEF; b++)
            begin
                raw_down[b] = 1'b0;
                stable_down[b] = 1'b0;
                long_fired[b] = 1'b0;
                edge_stamp[b] = '0;
                press_stamp[b] = '0;
            end
            queued_events.delete();
            expected_events.delete();
            mismatches = 0;
            checked = 0;
            popped = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual %h",
                             $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_valid", 8'(want.event_valid), 8'(out_data.event_valid));
                    check_field("event_key", want.event_key, out_data.event_key);
                    check_field("event_long", 8'(want.event_long), 8'(out_data.event_long));
                    check_field("events_pending", 8'(want.events_pending),
                                8'(out_data.events_pending));
                    checked++;
                    if (want.event_valid)
                        popped++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    bdclp_pkg::REG_DEBOUNCE_TIME:   debounce_ms = cfg_data[15:0];
                    bdclp_pkg::REG_LONG_PRESS_TIME: long_ms = cfg_data[15:0];
                    bdclp_pkg::REG_BUTTONS_IN_USE:  buttons_in_use = cfg_data[3:0];
                    bdclp_pkg::REG_ACTIVE_LOW_MASK: active_low_mask = cfg_data[7:0];
                    bdclp_pkg::REG_KEY_CODE_TABLE:  key_codes = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_events.push_back(step_buttons(in_data));
        end
        fail_count <= mismatches;
        events_outstanding <= expected_events.size();
        results_checked <= checked;
        events_popped <= popped;
    end

endmodule

FILE: bench/button_debounce_click_long_press_tb.sv
`timescale 1ns / 100ps

module button_debounce_click_long_press_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENTS = 12;
    localparam int SEGMENT_ITEMS = 138;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [bdclp_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd5;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    bdclp_pkg::in_item_t               in_data = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    bdclp_pkg::out_item_t              out_data;
    logic                              cfg_we = 1'b0;
    logic [bdclp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bdclp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int events_outstanding;
    int results_checked;
    int events_popped;

    int          cycles = 0;
    int          send_idle_pct = 31;
    int          recv_idle_pct = 60;
    int          poll_pct;
    int          items_sent = 0;
    int          settings_done = 0;
    logic [15:0] debounce_ms = bdclp_pkg::DEBOUNCE_TIME_RST;
    logic [15:0] long_ms = bdclp_pkg::LONG_PRESS_TIME_RST;
    logic [31:0] now_ms = '0;
    logic [7:0]  held_pins = 8'hFF;
    bdclp_pkg::in_item_t sample;
    int unsigned step;
    int          roll;

    button_debounce_click_long_press i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    button_event_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .in_data            (in_data),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .out_data           (out_data),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .fail_count         (fail_count),
        .events_outstanding (events_outstanding),
        .results_checked    (results_checked),
        .events_popped      (events_popped)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("button_debounce_click_long_press test failed");
            $finish;
        end
    end

    task automatic send_item(input bdclp_pkg::in_item_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_fields(input logic op, input logic [31:0] stamp,
                               input logic [7:0] pins);
        bdclp_pkg::in_item_t item;
        item.op = op;
        item.now_ms = stamp;
        item.pin_levels = pins;
        send_item(item);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (events_outstanding != 0);
    endtask

    task automatic write_reg(input logic [bdclp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bdclp_pkg::CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] deb, input logic [15:0] lp,
                                input logic [3:0] btn, input logic [7:0] mask,
                                input logic [63:0] keys);
        write_reg(bdclp_pkg::REG_DEBOUNCE_TIME, {48'd0, deb});
        write_reg(bdclp_pkg::REG_LONG_PRESS_TIME, {48'd0, lp});
        write_reg(bdclp_pkg::REG_BUTTONS_IN_USE, {60'd0, btn});
        write_reg(bdclp_pkg::REG_ACTIVE_LOW_MASK, {56'd0, mask});
        write_reg(bdclp_pkg::REG_KEY_CODE_TABLE, keys);
        write_reg(REG_UNUSED_LO + 3'($urandom_range(2)), {$urandom, $urandom});
        cfg_we <= 1'b0;
        @(posedge clk);
        debounce_ms = deb;
        long_ms = lp;
        settings_done++;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fields(1'b1, 32'd0, 8'hFF);
        send_fields(1'b0, 32'd5, 8'h00);
        send_fields(1'b0, 32'd20, 8'hFF);
        send_fields(1'b0, 32'd25, 8'h00);
        send_fields(1'b0, 32'd55, 8'h00);
        send_fields(1'b1, 32'd1055, 8'h00);
        send_fields(1'b0, 32'd1060, 8'hFF);
        send_fields(1'b1, 32'd1090, 8'hFF);
        drain();

        program_regs(16'd0, 16'd0, 4'd15, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
        send_fields(1'b0, 32'hFFFF_FFFF, 8'hFF);
        send_fields(1'b1, 32'd0, 8'h00);
        send_fields(1'b1, 32'd1, 8'h00);
        send_fields(1'b1, 32'd2, 8'h00);
        drain();

        program_regs(16'd10, 16'hFFFF, 4'd3, 8'hAA, 64'h0123_4567_89AB_CDEF);
        send_fields(1'b0, 32'd100, 8'h07);
        send_fields(1'b0, 32'd110, 8'h07);
        send_fields(1'b1, 32'd120, 8'h00);
        send_fields(1'b1, 32'd130, 8'h00);
        send_fields(1'b1, 32'd140, 8'h02);
        send_fields(1'b1, 32'd150, 8'h02);
        drain();

        program_regs(16'd10, 16'd50, 4'd0, 8'h55, 64'h8040_2010_0804_0201);
        send_fields(1'b1, 32'd200, 8'h55);
        send_fields(1'b1, 32'd300, 8'hAA);
        now_ms = 32'd300;

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            case (seg / 4)
                0:
                begin
                    send_idle_pct = 31;
                    recv_idle_pct <= 60;
                end
                1:
                begin
                    send_idle_pct = 60;
                    recv_idle_pct <= 31;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            if (seg == 0)
                program_regs(16'd0, 16'd0, 4'd8, 8'h00, {$urandom, $urandom});
            else if (seg == 1)
                program_regs(16'hFFFF, 16'hFFFF, 4'd15, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
            else
                program_regs(16'($urandom_range(40)), 16'($urandom_range(300)),
                             4'($urandom_range(15)), 8'($urandom), {$urandom, $urandom});
            case ($urandom_range(2))
                0:       poll_pct = 5;
                1:       poll_pct = 40;
                default: poll_pct = 90;
            endcase
            for (int k = 0; k < SEGMENT_ITEMS; k++)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    step = $urandom;
                else if (roll < 15)
                    step = $urandom_range(long_ms / 4 + 2, 1);
                else
                    step = $urandom_range(debounce_ms / 2 + 2, 0);
                now_ms = now_ms + step;
                if ($urandom_range(11) == 0)
                    held_pins[$urandom_range(7)] = ~held_pins[$urandom_range(7)];
                sample.pin_levels = held_pins;
                roll = $urandom_range(99);
                if (roll < 8)
                    sample.pin_levels = 8'($urandom);
                else if (roll < 30)
                    sample.pin_levels = held_pins ^ (8'd1 << $urandom_range(7));
                sample.op = ($urandom_range(99) < poll_pct);
                sample.now_ms = now_ms;
                send_item(sample);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d samples sent under %0d register settings across three idling phases",
                 items_sent, settings_done);
        $display("%0d results compared, %0d of them carried a popped event",
                 results_checked, events_popped);
        if (fail_count == 0)
            $display("button_debounce_click_long_press test passed");
        else
            $display("button_debounce_click_long_press test failed");
        $finish;
    end

endmodule

FILE: button_debounce_click_long_press.f
hdl/bdclp_pkg.sv
hdl/bdclp_ctrl.sv
hdl/bdclp_dp.sv
hdl/button_debounce_click_long_press.sv
hdl/bdclp_checker.sv
bench/button_event_checker.sv
bench/button_debounce_click_long_press_tb.sv
